FILE: rtl/core/blist_pkg.sv
// ----------------------------------------------------------------------------
// Bounded array list package
// Shared constants, operation and status codes, and the per-cell control
// types for the bounded array list.
// ----------------------------------------------------------------------------
package blist_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_LOCATE = 3'd2,
        OP_SORTED = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_EMPTY    = 3'd2,
        STS_BADPOS   = 3'd3,
        STS_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cell_flags;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

FILE: rtl/core/blist_cell.sv
// ----------------------------------------------------------------------------
// Bounded array list cell
// Holds one list entry. Takes a new value, its left or its right neighbor's
// entry, and registers its comparison against an incoming request value.
// ----------------------------------------------------------------------------
module blist_cell (
    input  logic                             i_clk,
    input  blist_pkg::t_cell_cmd             i_cmd,
    input  logic                             i_cmp_en,
    input  logic signed [blist_pkg::DATA_W-1:0] i_cmp_value,
    input  logic signed [blist_pkg::DATA_W-1:0] i_load_value,
    input  logic signed [blist_pkg::DATA_W-1:0] i_left,
    input  logic signed [blist_pkg::DATA_W-1:0] i_right,
    output logic signed [blist_pkg::DATA_W-1:0] o_data,
    output blist_pkg::t_cell_flags           o_flags
);

    logic signed [blist_pkg::DATA_W-1:0] r_data;
    logic signed [blist_pkg::DATA_W-1:0] n_data;
    blist_pkg::t_cell_flags              r_flags;

    always_comb begin
        unique case (i_cmd)
            blist_pkg::CELL_LOAD:       n_data = i_load_value;
            blist_pkg::CELL_FROM_LEFT:  n_data = i_left;
            blist_pkg::CELL_FROM_RIGHT: n_data = i_right;
            default:                    n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_cmp_en) begin
            r_flags.eq <= (r_data == i_cmp_value);
            r_flags.lt <= (r_data < i_cmp_value);
        end
    end

    assign o_data  = r_data;
    assign o_flags = r_flags;

endmodule

FILE: rtl/core/bounded_array_list.sv
// ----------------------------------------------------------------------------
// Bounded array list
// Fixed-capacity ordered list of signed 32-bit words built as a row of cells,
// with insert, delete, locate, sorted insert and read requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (i_operation, i_value, i_position) is taken on a rising
//   edge where start is high and busy is low. On that edge every cell
//   compares its entry with i_value and keeps the result.
//   In the following cycle (busy high) the control picks the target index
//   (from the cell flags for locate and sorted insert, else the position);
//   on insert or delete the cells from it onward shift in parallel toward
//   or away from it. The result word is registered at the end of that cycle
//   and presented for exactly one cycle with o_strobe high, starting at the
//   edge after the accept edge, after the registered compare in the cells
//   and the shift cycle. No new request is taken while busy is high.
//   The receiver cannot stall: each result word is valid for one cycle only.
//   Reset (synchronous, active low) empties the list and drops any pending
//   result; entry contents are not cleared, only the count.
// ----------------------------------------------------------------------------
module bounded_array_list (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [2:0]                           i_operation,
    input  logic signed [blist_pkg::DATA_W-1:0]  i_value,
    input  logic [blist_pkg::IDX_W-1:0]          i_position,
    output logic                                 o_strobe,
    output logic [2:0]                           o_status,
    output logic [blist_pkg::IDX_W-1:0]          o_found_index,
    output logic signed [blist_pkg::DATA_W-1:0]  o_read_value,
    output logic [blist_pkg::CNT_W-1:0]          o_element_count
);

    localparam int N = blist_pkg::CAPACITY;

    blist_pkg::t_state r_state, n_state;

    blist_pkg::t_op                       r_op;
    logic signed [blist_pkg::DATA_W-1:0]  r_val;
    logic [blist_pkg::IDX_W-1:0]          r_pos;

    logic [blist_pkg::CNT_W-1:0]          r_count, n_count;
    logic                                 r_strobe, n_strobe;
    blist_pkg::t_status                   r_status, n_status;
    logic [blist_pkg::IDX_W-1:0]          r_index, n_index;
    logic signed [blist_pkg::DATA_W-1:0]  r_rdata, n_rdata;

    logic signed [blist_pkg::DATA_W-1:0]  cell_data  [N];
    blist_pkg::t_cell_flags               cell_flags [N];
    blist_pkg::t_cell_cmd                 cell_cmd   [N];

    logic                                 accept;
    logic [N-1:0]                         in_list;
    logic                                 match_hit;
    logic [blist_pkg::IDX_W-1:0]          match_idx;
    logic                                 slot_hit;
    logic [blist_pkg::IDX_W-1:0]          slot_idx;
    logic [blist_pkg::CNT_W-1:0]          pos_ext;
    logic                                 pos_oob;
    logic                                 is_full;
    logic                                 do_insert;
    logic                                 do_delete;
    logic [blist_pkg::IDX_W-1:0]          ins_pos;
    logic [blist_pkg::CNT_W-1:0]          ins_ext;

    assign accept = start && (r_state == blist_pkg::S_IDLE);
    assign busy   = (r_state == blist_pkg::S_EXEC);

    // Row of cells; each takes its neighbor's entry during a shift.
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic signed [blist_pkg::DATA_W-1:0] left_data;
        logic signed [blist_pkg::DATA_W-1:0] right_data;
        if (g == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_left
            assign left_data = cell_data[g-1];
        end
        if (g == N - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_right
            assign right_data = cell_data[g+1];
        end
        blist_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cell_cmd[g]),
            .i_cmp_en     (accept),
            .i_cmp_value  (i_value),
            .i_load_value (r_val),
            .i_left       (left_data),
            .i_right      (right_data),
            .o_data       (cell_data[g]),
            .o_flags      (cell_flags[g])
        );
    end

    // First matching entry and first entry not below the value.
    always_comb begin
        match_hit = 1'b0;
        match_idx = '0;
        slot_hit  = 1'b0;
        slot_idx  = '0;
        for (int k = 0; k < N; k++) begin
            in_list[k] = (blist_pkg::CNT_W'(k) < r_count);
        end
        for (int k = N - 1; k >= 0; k--) begin
            if (in_list[k] && cell_flags[k].eq) begin
                match_hit = 1'b1;
                match_idx = blist_pkg::IDX_W'(k);
            end
            if (in_list[k] && !cell_flags[k].lt) begin
                slot_hit = 1'b1;
                slot_idx = blist_pkg::IDX_W'(k);
            end
        end
    end

    assign pos_ext = {1'b0, r_pos};
    assign pos_oob = (pos_ext >= blist_pkg::CNT_W'(N));
    assign is_full = (r_count >= blist_pkg::CNT_W'(N));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_index   = r_index;
        n_rdata   = r_rdata;
        do_insert = 1'b0;
        do_delete = 1'b0;
        ins_pos   = r_pos;

        unique case (r_state)
            blist_pkg::S_IDLE: begin
                if (start) begin
                    n_state = blist_pkg::S_EXEC;
                end
            end
            blist_pkg::S_EXEC: begin
                n_state  = blist_pkg::S_IDLE;
                n_strobe = 1'b1;
                n_status = blist_pkg::STS_BADPOS;
                n_index  = '0;
                n_rdata  = '0;
                unique case (r_op)
                    blist_pkg::OP_INSERT: begin
                        if (pos_oob || pos_ext > r_count) begin
                            n_status = blist_pkg::STS_BADPOS;
                        end else if (is_full) begin
                            n_status = blist_pkg::STS_FULL;
                        end else begin
                            do_insert = 1'b1;
                            n_status  = blist_pkg::STS_OK;
                            n_index   = r_pos;
                        end
                    end
                    blist_pkg::OP_DELETE, blist_pkg::OP_READ: begin
                        if (pos_oob) begin
                            n_status = blist_pkg::STS_BADPOS;
                        end else if (r_count == '0) begin
                            n_status = blist_pkg::STS_EMPTY;
                        end else if (pos_ext >= r_count) begin
                            n_status = blist_pkg::STS_BADPOS;
                        end else begin
                            n_status = blist_pkg::STS_OK;
                            n_index  = r_pos;
                            if (r_op == blist_pkg::OP_DELETE) begin
                                do_delete = 1'b1;
                            end else begin
                                n_rdata = cell_data[r_pos];
                            end
                        end
                    end
                    blist_pkg::OP_LOCATE: begin
                        if (match_hit) begin
                            n_status = blist_pkg::STS_OK;
                            n_index  = match_idx;
                        end else begin
                            n_status = blist_pkg::STS_NOTFOUND;
                        end
                    end
                    blist_pkg::OP_SORTED: begin
                        if (is_full) begin
                            n_status = blist_pkg::STS_FULL;
                        end else begin
                            // With no entry at or above the value, append.
                            ins_pos   = slot_hit ? slot_idx : r_count[blist_pkg::IDX_W-1:0];
                            do_insert = 1'b1;
                            n_status  = blist_pkg::STS_OK;
                            n_index   = ins_pos;
                        end
                    end
                    default: begin
                        n_status = blist_pkg::STS_BADPOS;
                    end
                endcase
                if (do_insert) begin
                    n_count = r_count + 1'b1;
                end else if (do_delete) begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_state = blist_pkg::S_IDLE;
            end
        endcase
    end

    // Per-cell shift commands around the insert or delete point.
    assign ins_ext = {1'b0, ins_pos};
    always_comb begin
        for (int k = 0; k < N; k++) begin
            cell_cmd[k] = blist_pkg::CELL_HOLD;
            if (do_insert) begin
                if (blist_pkg::CNT_W'(k) == ins_ext) begin
                    cell_cmd[k] = blist_pkg::CELL_LOAD;
                end else if (blist_pkg::CNT_W'(k) > ins_ext &&
                             blist_pkg::CNT_W'(k) <= r_count) begin
                    cell_cmd[k] = blist_pkg::CELL_FROM_LEFT;
                end
            end else if (do_delete) begin
                if (blist_pkg::CNT_W'(k) >= pos_ext &&
                    blist_pkg::CNT_W'(k + 1) < r_count) begin
                    cell_cmd[k] = blist_pkg::CELL_FROM_RIGHT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= blist_pkg::S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= blist_pkg::t_op'(i_operation);
            r_val <= i_value;
            r_pos <= i_position;
        end
        r_status <= n_status;
        r_index  <= n_index;
        r_rdata  <= n_rdata;
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_found_index   = r_index;
    assign o_read_value    = r_rdata;
    assign o_element_count = r_count;

endmodule

FILE: tb/sv/bounded_array_list_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded array list testbench
// Drives insert, delete, locate, sorted insert, read and unused request words
// into the list and checks every result word against an in-bench model of the
// list that tracks its entries and count.
// ----------------------------------------------------------------------------
module bounded_array_list_tb;

    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int RANDOM_WORDS = 1025;
    localparam int CALM_TAIL    = 100;
    localparam int QUIET_LIMIT  = 200;
    localparam int DRAIN_CYCLES = 4;

    localparam logic signed [blist_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [blist_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [2:0]                          op;
        logic signed [blist_pkg::DATA_W-1:0] value;
        logic [blist_pkg::IDX_W-1:0]         pos;
    } t_list_req;

    typedef struct {
        blist_pkg::t_status                  status;
        logic [blist_pkg::IDX_W-1:0]         index;
        logic signed [blist_pkg::DATA_W-1:0] data;
        logic [blist_pkg::CNT_W-1:0]         count;
    } t_list_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [2:0]                          i_operation = '0;
    logic signed [blist_pkg::DATA_W-1:0] i_value = '0;
    logic [blist_pkg::IDX_W-1:0]         i_position = '0;
    logic                                o_strobe;
    logic [2:0]                          o_status;
    logic [blist_pkg::IDX_W-1:0]         o_found_index;
    logic signed [blist_pkg::DATA_W-1:0] o_read_value;
    logic [blist_pkg::CNT_W-1:0]         o_element_count;

    t_list_req    pending_q[$];
    t_list_result result_q[$];

    logic signed [blist_pkg::DATA_W-1:0] list_data[blist_pkg::CAPACITY];
    int           list_len = 0;

    logic         word_taken = 1'b0;
    int           gap_left = 0;
    int           drive_count = 0;
    int           calm_from = 0;
    int           quiet_cycles = 0;
    int           mismatch_count = 0;
    t_list_req    drive_req;

    bounded_array_list dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_found_index   (o_found_index),
        .o_read_value    (o_read_value),
        .o_element_count (o_element_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void list_place(int at, logic signed [blist_pkg::DATA_W-1:0] v);
        for (int k = list_len; k > at; k--) begin
            list_data[k] = list_data[k-1];
        end
        list_data[at] = v;
        list_len++;
    endfunction

    // Applies one request to the list model and returns the result word.
    function automatic t_list_result list_apply(t_list_req rq);
        t_list_result r;
        int p;
        int k;
        r.status = blist_pkg::STS_BADPOS;
        r.index  = '0;
        r.data   = '0;
        p = int'(rq.pos);
        case (rq.op)
            blist_pkg::OP_INSERT: begin
                if (p >= blist_pkg::CAPACITY || p > list_len) begin
                    r.status = blist_pkg::STS_BADPOS;
                end else if (list_len >= blist_pkg::CAPACITY) begin
                    r.status = blist_pkg::STS_FULL;
                end else begin
                    list_place(p, rq.value);
                    r.status = blist_pkg::STS_OK;
                    r.index  = rq.pos;
                end
            end
            blist_pkg::OP_DELETE, blist_pkg::OP_READ: begin
                if (p >= blist_pkg::CAPACITY) begin
                    r.status = blist_pkg::STS_BADPOS;
                end else if (list_len == 0) begin
                    r.status = blist_pkg::STS_EMPTY;
                end else if (p >= list_len) begin
                    r.status = blist_pkg::STS_BADPOS;
                end else begin
                    r.status = blist_pkg::STS_OK;
                    r.index  = rq.pos;
                    if (rq.op == blist_pkg::OP_READ) begin
                        r.data = list_data[p];
                    end else begin
                        for (k = p; k + 1 < list_len; k++) begin
                            list_data[k] = list_data[k+1];
                        end
                        list_len--;
                    end
                end
            end
            blist_pkg::OP_LOCATE: begin
                r.status = blist_pkg::STS_NOTFOUND;
                for (k = 0; k < list_len; k++) begin
                    if (list_data[k] == rq.value) begin
                        r.status = blist_pkg::STS_OK;
                        r.index  = blist_pkg::IDX_W'(k);
                        break;
                    end
                end
            end
            blist_pkg::OP_SORTED: begin
                if (list_len >= blist_pkg::CAPACITY) begin
                    r.status = blist_pkg::STS_FULL;
                end else begin
                    k = 0;
                    while (k < list_len && $signed(list_data[k]) < $signed(rq.value)) begin
                        k++;
                    end
                    list_place(k, rq.value);
                    r.status = blist_pkg::STS_OK;
                    r.index  = blist_pkg::IDX_W'(k);
                end
            end
            default: r.status = blist_pkg::STS_BADPOS;
        endcase
        r.count = blist_pkg::CNT_W'(list_len);
        return r;
    endfunction

    // Driver: holds a word on the request ports until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || word_taken) begin
            if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_q.size() != 0) begin
                drive_req   = pending_q.pop_front();
                start       <= 1'b1;
                i_operation <= drive_req.op;
                i_value     <= drive_req.value;
                i_position  <= drive_req.pos;
                // Idle gaps come only in every other stretch of 64 words, none in the tail.
                if (drive_count < calm_from && (drive_count / 64) % 2 == 0
                        && $urandom_range(0, 2) == 0) begin
                    gap_left <= $urandom_range(1, 16);
                end
                drive_count <= drive_count + 1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks result words, then predicts for a word taken on this edge.
    always @(posedge i_clk) begin : monitor
        t_list_result exp_r;
        t_list_req    rq;
        if (!i_rst_n) begin
            word_taken   <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (o_strobe) begin
                if (result_q.size() == 0) begin
                    $error("result word with no request outstanding");
                    mismatch_count++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (o_status !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d", exp_r.status, o_status);
                        mismatch_count++;
                    end
                    if (o_found_index !== exp_r.index) begin
                        $error("found_index: expected %0d, actual %0d",
                               exp_r.index, o_found_index);
                        mismatch_count++;
                    end
                    if (o_read_value !== exp_r.data) begin
                        $error("read_value: expected %0d, actual %0d",
                               exp_r.data, o_read_value);
                        mismatch_count++;
                    end
                    if (o_element_count !== exp_r.count) begin
                        $error("element_count: expected %0d, actual %0d",
                               exp_r.count, o_element_count);
                        mismatch_count++;
                    end
                end
            end
            word_taken <= start && !busy;
            if (start && !busy) begin
                rq.op    = i_operation;
                rq.value = i_value;
                rq.pos   = i_position;
                result_q.push_back(list_apply(rq));
            end
            if (o_strobe || (start && !busy)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("bounded_array_list test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic add_word(logic [2:0] op, logic signed [blist_pkg::DATA_W-1:0] v, int p);
        t_list_req rq;
        rq.op    = op;
        rq.value = v;
        rq.pos   = blist_pkg::IDX_W'(p);
        pending_q.push_back(rq);
    endtask

    initial begin
        logic [2:0]                          op;
        logic signed [blist_pkg::DATA_W-1:0] v;
        int                                  pick;
        bit                                  grow;

        // Empty list, bad positions and unused operation codes.
        add_word(blist_pkg::OP_READ,   0, 0);
        add_word(blist_pkg::OP_DELETE, 0, 3);
        add_word(blist_pkg::OP_LOCATE, 5, 0);
        add_word(blist_pkg::OP_INSERT, 9, 1);
        add_word(OP_RSVD5,  VAL_MAX, 7);
        add_word(OP_RSVD6,  VAL_MIN, 0);
        add_word(OP_RSVD7,  -1, 5);
        // Fill to capacity with extremes and duplicates.
        add_word(blist_pkg::OP_INSERT, VAL_MIN, 0);
        add_word(blist_pkg::OP_INSERT, VAL_MAX, 1);
        add_word(blist_pkg::OP_INSERT, 0, 1);
        add_word(blist_pkg::OP_SORTED, -1, 0);
        add_word(blist_pkg::OP_SORTED, 0, 0);
        add_word(blist_pkg::OP_SORTED, VAL_MAX, 0);
        add_word(blist_pkg::OP_SORTED, VAL_MIN, 0);
        add_word(blist_pkg::OP_INSERT, 32'sh5a5a_a5a5, 7);
        // Full list.
        add_word(blist_pkg::OP_INSERT, 1, 0);
        add_word(blist_pkg::OP_SORTED, 1, 0);
        add_word(blist_pkg::OP_LOCATE, 0, 0);
        add_word(blist_pkg::OP_LOCATE, 12345, 0);
        add_word(blist_pkg::OP_READ,   0, 7);
        add_word(blist_pkg::OP_READ,   0, 0);
        // Shrink from both ends and reach past the count.
        add_word(blist_pkg::OP_DELETE, 0, 7);
        add_word(blist_pkg::OP_READ,   0, 7);
        add_word(blist_pkg::OP_DELETE, 0, 0);
        add_word(blist_pkg::OP_DELETE, 0, 6);

        // Alternate growing and shrinking phases so the list often hits
        // both full and empty with random content in between.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            grow = ((i / 40) % 2 == 0);
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                case ($urandom_range(0, 2))
                    0:       op = OP_RSVD5;
                    1:       op = OP_RSVD6;
                    default: op = OP_RSVD7;
                endcase
            end else if (pick < (grow ? 34 : 19)) begin
                op = blist_pkg::OP_INSERT;
            end else if (pick < (grow ? 64 : 34)) begin
                op = blist_pkg::OP_SORTED;
            end else if (pick < (grow ? 74 : 69)) begin
                op = blist_pkg::OP_DELETE;
            end else if (pick < 87) begin
                op = blist_pkg::OP_LOCATE;
            end else begin
                op = blist_pkg::OP_READ;
            end
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                v = $urandom_range(0, 5) - 3;
            end else if (pick == 5) begin
                v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            end else begin
                v = $urandom;
            end
            add_word(op, v, $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 7));
        end
        calm_from = pending_q.size() - CALM_TAIL;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || start) @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (result_q.size() != 0) begin
            $error("%0d result words never arrived", result_q.size());
        end
        if (mismatch_count == 0 && result_q.size() == 0) begin
            $display("bounded_array_list test passed");
        end else begin
            $display("bounded_array_list test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/blist_pkg.sv
rtl/core/blist_cell.sv
rtl/core/bounded_array_list.sv
tb/sv/bounded_array_list_tb.sv
